/* hw/rtl/hpt_pkg.sv */
// Shared types and constants for the histogram percentile threshold block.
`default_nettype none

package hpt_pkg;

    // Default number of histogram buckets.
    localparam int BUCKETS_DEF = 512;

    // Width of one bucket count and of a selected bucket index on the ports.
    localparam int CNT_W = 32;
    localparam int SEL_W = 9;

    // Register reset values.
    localparam logic [CNT_W-1:0] LIMIT_RESET = 32'd100;
    localparam logic [SEL_W-1:0] THR_RESET   = 9'd8;

    typedef logic [SEL_W-1:0] t_sel;

    // Register indexes of the configuration port.
    typedef logic [0:0] t_reg_idx;
    localparam t_reg_idx REG_SMALL_TOTAL_LIMIT = 1'b0;
    localparam t_reg_idx REG_START_THRESH      = 1'b1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Scan result offered by the controller to the result stage.
    typedef struct packed {
        logic valid;
        t_sel heap;
        t_sel send;
    } t_done;

endpackage

`default_nettype wire

/* hw/rtl/hpt_bucket_mem.sv */
// Bucket count store: one write port, one read port with registered read data.
`default_nettype none

module hpt_bucket_mem
    import hpt_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int IW      = $clog2(BUCKETS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IW-1:0]    i_waddr,
    input  wire logic [CNT_W-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [IW-1:0]    i_raddr,
    output logic      [CNT_W-1:0] o_rdata
);

    logic [CNT_W-1:0] r_mem [BUCKETS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/hpt_ctrl.sv */
// Load and scan controller: fills the bucket store, then scans it for both thresholds.
`default_nettype none

module hpt_ctrl
    import hpt_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF,
    parameter int IW      = $clog2(BUCKETS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [CNT_W-1:0] i_bucket_count,
    input  wire logic             i_last,
    input  wire logic [CNT_W-1:0] i_limit,
    output logic                  o_we,
    output logic      [IW-1:0]    o_waddr,
    output logic      [CNT_W-1:0] o_wdata,
    output logic                  o_re,
    output logic      [IW-1:0]    o_raddr,
    input  wire logic [CNT_W-1:0] i_rdata,
    output t_done                 o_done,
    input  wire logic             i_done_ready
);

    localparam int PW = $clog2(BUCKETS + 1);
    localparam int TW = CNT_W + IW;
    localparam int MW = TW + 5;
    localparam logic [IW-1:0] TOP_IDX = IW'(BUCKETS - 1);
    localparam logic [PW-1:0] DEPTH   = PW'(BUCKETS);

    t_state r_state, n_state;

    logic [PW-1:0] r_load_pos;
    logic [TW-1:0] r_total;
    logic [PW-1:0] r_rd_idx;
    logic          r_s1_valid;
    logic [IW-1:0] r_s1_idx;
    logic          r_s2_valid;
    logic [IW-1:0] r_s2_idx;
    logic [TW-1:0] r_cum;
    logic          r_heap_found;
    logic          r_send_found;
    logic [IW-1:0] r_heap_idx;
    logic [IW-1:0] r_send_idx;

    logic          in_acc;
    logic          store;
    logic          issue;
    logic          scan_done;
    logic          low_total;
    logic          heap_hit;
    logic          send_hit;
    logic [MW-1:0] cum20;
    logic [MW-1:0] cum10;
    logic [MW-1:0] tot_ext;

    assign in_acc = i_in_valid && !o_in_stall;
    assign store  = in_acc && (r_load_pos < DEPTH);

    assign o_we    = store;
    assign o_waddr = r_load_pos[IW-1:0];
    assign o_wdata = i_bucket_count;

    assign issue   = (r_state == ST_SCAN) && (r_rd_idx < r_load_pos);
    assign o_re    = issue;
    assign o_raddr = r_rd_idx[IW-1:0];

    assign scan_done = (r_state == ST_SCAN) && !issue && !r_s1_valid && !r_s2_valid;

    // Exact percentile tests: cum*20 >= total and cum*10 >= total, or cum >= total for both at a low total.
    assign cum20     = (MW'(r_cum) << 4) + (MW'(r_cum) << 2);
    assign cum10     = (MW'(r_cum) << 3) + (MW'(r_cum) << 1);
    assign tot_ext   = MW'(r_total);
    assign low_total = r_total <= TW'(i_limit);
    assign heap_hit  = low_total ? (r_cum >= r_total) : (cum20 >= tot_ext);
    assign send_hit  = low_total ? (r_cum >= r_total) : (cum10 >= tot_ext);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (in_acc && i_last) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_done_ready) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        o_done     = '0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
            end
            ST_SCAN: begin
                o_in_stall = 1'b1;
            end
            ST_FINISH: begin
                o_done.valid = 1'b1;
                if (r_total == '0) begin
                    o_done.heap = t_sel'(TOP_IDX);
                    o_done.send = t_sel'(TOP_IDX);
                end else begin
                    o_done.heap = t_sel'(r_heap_idx);
                    o_done.send = t_sel'(r_send_idx);
                end
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_LOAD;
            r_load_pos   <= '0;
            r_total      <= '0;
            r_rd_idx     <= '0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_cum        <= '0;
            r_heap_found <= 1'b0;
            r_send_found <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid;
            if (store) begin
                r_load_pos <= r_load_pos + 1'b1;
                r_total    <= r_total + TW'(i_bucket_count);
            end
            if (r_state == ST_LOAD) begin
                r_rd_idx     <= '0;
                r_cum        <= '0;
                r_heap_found <= 1'b0;
                r_send_found <= 1'b0;
            end
            if (issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (r_s1_valid) begin
                r_cum <= r_cum + TW'(i_rdata);
            end
            if (r_s2_valid && !r_heap_found && heap_hit) begin
                r_heap_found <= 1'b1;
            end
            if (r_s2_valid && !r_send_found && send_hit) begin
                r_send_found <= 1'b1;
            end
            if ((r_state == ST_FINISH) && i_done_ready) begin
                r_load_pos <= '0;
                r_total    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= r_rd_idx[IW-1:0];
        r_s2_idx <= r_s1_idx;
        if (r_s2_valid && !r_heap_found && heap_hit) begin
            r_heap_idx <= r_s2_idx;
        end
        if (r_s2_valid && !r_send_found && send_hit) begin
            r_send_idx <= r_s2_idx;
        end
    end

`ifndef SYNTHESIS
    a_pipe_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid || r_s2_valid) |-> (r_state == ST_SCAN))
        else $error("scan pipeline busy outside the scan");

    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_load_pos != '0))
        else $error("scan started with no stored bucket");

    a_both_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FINISH) && (r_total != '0)) |-> (r_heap_found && r_send_found))
        else $error("scan ended without both thresholds");

    a_heap_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_FINISH) && (r_total != '0)) |-> (r_heap_idx <= r_send_idx))
        else $error("heap threshold lies above send threshold");
`endif

endmodule

`default_nettype wire

/* hw/rtl/histogram_percentile_threshold.sv */
// Top level of the histogram percentile threshold block.
`default_nettype none

// The block takes one histogram, one bucket count per item in ascending bucket
// order, with the last item marked. Counts are written into a single-port-write,
// single-port-read bucket store at one item per cycle unless stalled, while a
// running total is kept; counts beyond BUCKETS are dropped, but their last mark
// still ends the histogram. After the last item the store is read back one bucket
// per cycle and a cumulative count is compared against the total to find the 5%
// (heap) and 10% (send) thresholds, or the 100% threshold for both when the total
// is at or below small_total_limit. A zero total selects the top bucket. The scan
// is bound by the single read port of the store; input is stalled during the
// scan, and also for as long as a full, stalled output register holds back the
// hand-off. A result item is emitted only when the heap bucket differs from the
// one kept from the previous round (initially the start threshold register, and
// reloaded whenever that register is written, unless a result is emitted at the
// same time). The result sits in an output register, so the next histogram loads
// while it waits. Selected indexes are 9 bits, masked when BUCKETS exceeds 512.
// The store needs no clearing after reset: only entries written in the current
// histogram are read. Registers: 0x0 small_total_limit, 0x4 start threshold.
module histogram_percentile_threshold
    import hpt_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [CNT_W-1:0] i_bucket_count,
    input  wire logic             i_last,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic      [SEL_W-1:0] o_heap_bucket,
    output logic      [SEL_W-1:0] o_send_bucket,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready
);

    localparam int IW = $clog2(BUCKETS);

    logic [CNT_W-1:0] r_small_total_limit;
    t_sel             r_start_thresh;
    t_sel             r_prev_heap;
    logic             r_out_valid;
    t_sel             r_out_heap;
    t_sel             r_out_send;

    logic             cfg_we;
    t_reg_idx         reg_idx;
    logic             done_ready;
    logic             done_fire;
    logic             changed;

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    logic [CNT_W-1:0] mem_wdata;
    logic             mem_re;
    logic [IW-1:0]    mem_raddr;
    logic [CNT_W-1:0] mem_rdata;
    t_done            done;

    hpt_bucket_mem #(
        .BUCKETS (BUCKETS),
        .IW      (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    hpt_ctrl #(
        .BUCKETS (BUCKETS),
        .IW      (IW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_bucket_count (i_bucket_count),
        .i_last         (i_last),
        .i_limit        (r_small_total_limit),
        .o_we           (mem_we),
        .o_waddr        (mem_waddr),
        .o_wdata        (mem_wdata),
        .o_re           (mem_re),
        .o_raddr        (mem_raddr),
        .i_rdata        (mem_rdata),
        .o_done         (done),
        .i_done_ready   (done_ready)
    );

    // Configuration port: zero wait states, register chosen by address bit 2.
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (reg_idx)
            REG_SMALL_TOTAL_LIMIT: prdata = r_small_total_limit;
            REG_START_THRESH:      prdata = 32'(r_start_thresh);
            default:               prdata = '0;
        endcase
    end

    // The scan result is taken as soon as the output register is free or
    // being emptied; it is emitted only when the heap bucket changed.
    assign done_ready = !r_out_valid || !i_out_stall;
    assign done_fire  = done.valid && done_ready;
    assign changed    = done.heap != r_prev_heap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_total_limit <= LIMIT_RESET;
            r_start_thresh      <= THR_RESET;
            r_prev_heap         <= THR_RESET;
            r_out_valid         <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (reg_idx)
                    REG_SMALL_TOTAL_LIMIT: begin
                        r_small_total_limit <= pwdata;
                    end
                    REG_START_THRESH: begin
                        r_start_thresh <= pwdata[SEL_W-1:0];
                        r_prev_heap    <= pwdata[SEL_W-1:0];
                    end
                    default: ;
                endcase
            end
            if (done_fire && changed) begin
                r_prev_heap <= done.heap;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_fire && changed) begin
            r_out_heap <= done.heap;
            r_out_send <= done.send;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_heap_bucket = r_out_heap;
    assign o_send_bucket = r_out_send;

endmodule

`default_nettype wire
